[rtl/aldpu_pkg.sv]
// ----------------------------------------------------------------------------
// aldpu_pkg
// Types and constants shared by the augmented-Lagrangian dual update block.
// ----------------------------------------------------------------------------
`default_nettype none

package aldpu_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_PENALTY_INITIAL     = 2'd0;
   localparam logic [1:0] CSR_PENALTY_FACTOR      = 2'd1;
   localparam logic [1:0] CSR_VIOLATION_TOLERANCE = 2'd2;

   // register reset values
   localparam logic [31:0] PENALTY_INITIAL_RESET     = 32'd65536;
   localparam logic [31:0] PENALTY_FACTOR_RESET      = 32'd655360;
   localparam logic [30:0] VIOLATION_TOLERANCE_RESET = 31'd66;

   // element kinds
   localparam logic KIND_BOUND = 1'b0;
   localparam logic KIND_GOAL  = 1'b1;

   // saturation limits for the dual sums, the violation and the penalty
   localparam logic signed [50:0] DUAL_MAX = 51'sd2147483647;
   localparam logic signed [50:0] DUAL_MIN = -51'sd2147483648;
   localparam logic signed [50:0] DUAL_ZERO = 51'sd0;
   localparam logic [30:0] VIOL_MAX = 31'h7FFF_FFFF;
   localparam logic [31:0] PENALTY_MAX = 32'hFFFF_FFFF;

   // input transaction
   typedef struct packed {
      logic               kind;
      logic signed [31:0] value;
      logic signed [31:0] upper_bound;
      logic signed [31:0] lower_bound;
      logic signed [31:0] reference;
      logic signed [31:0] upper_dual;
      logic [30:0]        lower_dual;
      logic               last;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [31:0] new_upper_dual;
      logic [30:0]        new_lower_dual;
      logic [30:0]        running_violation;
      logic               sweep_done;
      logic               converged;
      logic [31:0]        penalty_now;
   } rsp_type;

   // first stage: violations as sign and magnitude
   typedef struct packed {
      logic               kind;
      logic               last;
      logic signed [31:0] upper_dual;
      logic [30:0]        lower_dual;
      logic               up_neg;
      logic [31:0]        up_mag;
      logic               lo_neg;
      logic [31:0]        lo_mag;
   } viol_type;

endpackage

`default_nettype wire

[rtl/al_dual_penalty_update_top.sv]
// Path: an accepted transaction is held in the input register, then in the
// result register; it waits in the input register while the output is held.
// Throughput: one transaction per cycle while the output is not held; the
// violation stage and the multiply/update stage are each registered, and the
// penalty and running maximum feed back within the second stage.
// Reset: synchronous; control and state registers return to their reset
// values, the penalty to 65536 and the running maximum to zero. Pipeline empties.
// ----------------------------------------------------------------------------
// al_dual_penalty_update_top
// Streams bound and goal elements through an augmented-Lagrangian dual
// update, tracks the sweep's maximum violation and adapts the penalty.
// ----------------------------------------------------------------------------
`default_nettype none

module al_dual_penalty_update_top
   import aldpu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   // configuration and state registers
   logic [31:0] penalty_initial_ff, penalty_initial_in;
   logic [31:0] penalty_factor_ff, penalty_factor_in;
   logic [30:0] tolerance_ff, tolerance_in;
   logic [31:0] penalty_ff, penalty_in;
   logic [30:0] max_viol_ff, max_viol_in;

   // pipeline registers
   logic     s1_valid_ff, s1_valid_in;
   viol_type s1_ff, s1_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_ff, rsp_in;

   logic out_open;
   logic s1_adv;
   logic req_fire;
   logic csr_fire;

   // stage 1 signals
   logic signed [32:0] v_ext, x_ext, lb_ext;
   logic signed [32:0] up_fwd, up_rev, lo_fwd, lo_rev;

   // stage 2 signals
   logic               goal;
   logic               up_pos, lo_pos, du_pos;
   logic               act_up, act_lo;
   logic [63:0]        prod_up, prod_lo, prod_pen;
   logic [47:0]        p_up, p_lo, p_pen;
   logic signed [49:0] contrib_up, contrib_lo;
   logic signed [50:0] sum_up, sum_lo;
   logic signed [50:0] lo_limit;
   logic signed [31:0] new_up;
   logic [30:0]        new_lo;
   logic [31:0]        pos_up, pos_lo, peak;
   logic [30:0]        cand, run_max;
   logic               conv;
   logic [31:0]        pen_next;

   // handshake
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_open;
   assign req_ready = !s1_valid_ff || out_open;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 1: violations as sign and magnitude, both directions in parallel
   always_comb begin
      v_ext  = {req_data.value[31], req_data.value};
      x_ext  = (req_data.kind == KIND_GOAL)
               ? {req_data.reference[31], req_data.reference}
               : {req_data.upper_bound[31], req_data.upper_bound};
      lb_ext = {req_data.lower_bound[31], req_data.lower_bound};
      up_fwd = v_ext - x_ext;
      up_rev = x_ext - v_ext;
      lo_fwd = lb_ext - v_ext;
      lo_rev = v_ext - lb_ext;

      s1_in.kind       = req_data.kind;
      s1_in.last       = req_data.last;
      s1_in.upper_dual = req_data.upper_dual;
      s1_in.lower_dual = req_data.lower_dual;
      s1_in.up_neg     = up_fwd[32];
      s1_in.up_mag     = up_fwd[32] ? up_rev[31:0] : up_fwd[31:0];
      s1_in.lo_neg     = lo_fwd[32];
      s1_in.lo_mag     = lo_fwd[32] ? lo_rev[31:0] : lo_fwd[31:0];

      s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   end

   // stage 2: dual updates
   always_comb begin
      goal   = (s1_ff.kind == KIND_GOAL);
      up_pos = !s1_ff.up_neg && (s1_ff.up_mag != 32'd0);
      lo_pos = !s1_ff.lo_neg && (s1_ff.lo_mag != 32'd0);
      du_pos = !s1_ff.upper_dual[31] && (s1_ff.upper_dual != 32'sd0);
      act_up = goal || du_pos || up_pos;
      act_lo = (s1_ff.lower_dual != 31'd0) || lo_pos;

      prod_up = s1_ff.up_mag * penalty_ff;
      prod_lo = s1_ff.lo_mag * penalty_ff;
      p_up    = prod_up[63:16];
      p_lo    = prod_lo[63:16];

      contrib_up = s1_ff.up_neg ? -$signed({2'b00, p_up}) : $signed({2'b00, p_up});
      contrib_lo = s1_ff.lo_neg ? -$signed({2'b00, p_lo}) : $signed({2'b00, p_lo});

      sum_up = $signed({{19{s1_ff.upper_dual[31]}}, s1_ff.upper_dual})
             + (act_up ? $signed({contrib_up[49], contrib_up}) : DUAL_ZERO);
      sum_lo = $signed({20'd0, s1_ff.lower_dual})
             + (act_lo ? $signed({contrib_lo[49], contrib_lo}) : DUAL_ZERO);

      // upper or goal dual: goal saturates to the signed range, bound clamps at zero
      lo_limit = goal ? DUAL_MIN : DUAL_ZERO;
      if (sum_up > DUAL_MAX) begin
         new_up = 32'sh7FFF_FFFF;
      end else if (sum_up < lo_limit) begin
         new_up = lo_limit[31:0];
      end else begin
         new_up = sum_up[31:0];
      end

      // lower dual, zero for goal elements
      if (goal || (sum_lo < DUAL_ZERO)) begin
         new_lo = 31'd0;
      end else if (sum_lo > DUAL_MAX) begin
         new_lo = VIOL_MAX;
      end else begin
         new_lo = sum_lo[30:0];
      end
   end

   // stage 2: violation candidate, running maximum and penalty
   always_comb begin
      pos_up = up_pos ? s1_ff.up_mag : 32'd0;
      pos_lo = lo_pos ? s1_ff.lo_mag : 32'd0;
      peak   = (pos_up > pos_lo) ? pos_up : pos_lo;
      if (goal) begin
         cand = s1_ff.up_mag[31] ? VIOL_MAX : s1_ff.up_mag[30:0];
      end else begin
         cand = (peak[31:30] != 2'b00) ? VIOL_MAX : {peak[29:0], 1'b0};
      end
      run_max = (cand > max_viol_ff) ? cand : max_viol_ff;

      prod_pen = penalty_ff * penalty_factor_ff;
      p_pen    = prod_pen[63:16];
      conv     = s1_ff.last && (run_max < tolerance_ff);
      if (s1_ff.last && !conv) begin
         pen_next = (p_pen[47:32] != 16'd0) ? PENALTY_MAX : p_pen[31:0];
      end else begin
         pen_next = penalty_ff;
      end

      rsp_in.new_upper_dual    = new_up;
      rsp_in.new_lower_dual    = new_lo;
      rsp_in.running_violation = run_max;
      rsp_in.sweep_done        = s1_ff.last;
      rsp_in.converged         = conv;
      rsp_in.penalty_now       = pen_next;

      rsp_valid_in = out_open ? s1_valid_ff : rsp_valid_ff;
   end

   // state and configuration next values
   always_comb begin
      penalty_initial_in = penalty_initial_ff;
      penalty_factor_in  = penalty_factor_ff;
      tolerance_in       = tolerance_ff;
      penalty_in         = penalty_ff;
      max_viol_in        = max_viol_ff;

      if (s1_adv) begin
         penalty_in  = pen_next;
         max_viol_in = s1_ff.last ? 31'd0 : run_max;
      end

      if (csr_fire) begin
         case (csr_index)
            CSR_PENALTY_INITIAL: begin
               penalty_initial_in = csr_data;
               penalty_in         = csr_data;
            end
            CSR_PENALTY_FACTOR: begin
               penalty_factor_in = csr_data;
            end
            CSR_VIOLATION_TOLERANCE: begin
               tolerance_in = csr_data[30:0];
            end
            default: begin
            end
         endcase
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_initial_ff <= PENALTY_INITIAL_RESET;
         penalty_factor_ff  <= PENALTY_FACTOR_RESET;
         tolerance_ff       <= VIOLATION_TOLERANCE_RESET;
         penalty_ff         <= PENALTY_INITIAL_RESET;
         max_viol_ff        <= 31'd0;
         s1_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         penalty_initial_ff <= penalty_initial_in;
         penalty_factor_ff  <= penalty_factor_in;
         tolerance_ff       <= tolerance_in;
         penalty_ff         <= penalty_in;
         max_viol_ff        <= max_viol_in;
         s1_valid_ff        <= s1_valid_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
